// File: src/nsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence deframer package
// Parse phases, status codes and field widths shared by the deframer and its
// port checker.
// ----------------------------------------------------------------------------
package nsd_pkg;

   localparam int TALKER_CHARS = 5;
   localparam int TALKER_W = TALKER_CHARS * 8;
   localparam int SEEN_W = 3;

   localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd80;

   localparam logic [7:0] CHAR_START = 8'h24;
   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_BADHEX = 2'd1;
   localparam logic [1:0] ST_NOCRLF = 2'd2;
   localparam logic [1:0] ST_OVERLONG = 2'd3;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_TALKER,
      PH_SEP,
      PH_PAYLOAD,
      PH_CKHI,
      PH_CKLO,
      PH_CR,
      PH_LF
   } phase_type;

endpackage

// File: src/nmea_sentence_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence deframer
// A result is registered: it appears in the output register in the cycle after its beat.
// Throughput: one character per cycle while results are taken; the single output
// register frees as its result is taken, and a stalled result holds back the input.
// Reset: synchronous, active high; returns to hunting for the start
// character, clears the sentence state and sets the length limit to 80.
// ----------------------------------------------------------------------------
module nmea_sentence_deframer_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_item_kind,
   output logic [7:0]                  rsp_payload_char,
   output logic [nsd_pkg::TALKER_W-1:0] rsp_talker_id,
   output logic                        rsp_checksum_ok,
   output logic [1:0]                  rsp_frame_status,
   output logic [7:0]                  rsp_payload_count,
   input  logic                        csr_wr_en,
   input  logic [7:0]                  csr_wr_data
);

   nsd_pkg::phase_type phase_ff, phase_in;
   logic [nsd_pkg::TALKER_W-1:0] talker_ff, talker_in;
   logic [nsd_pkg::SEEN_W-1:0] seen_ff, seen_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] max_len_ff;

   logic                        rsp_valid_ff;
   logic                        kind_ff, kind_in;
   logic [7:0]                  char_ff, char_in;
   logic [nsd_pkg::TALKER_W-1:0] talker_out_ff;
   logic                        ok_ff, ok_in;
   logic [1:0]                  status_ff, status_in;
   logic [7:0]                  count_out_ff, count_out_in;
   logic                        res_valid;

   logic                        accept;
   logic [7:0]                  c;
   logic                        hex_ok;
   logic [3:0]                  hex_val;
   logic                        is_start;
   logic                        overlong;
   logic                        sum_match;

   assign c = req_rx_byte;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept = req_valid && req_ready;
   assign is_start = (c == nsd_pkg::CHAR_START);
   assign overlong = (count_ff >= max_len_ff);
   assign sum_match = (sum_ff == xor_ff);

   always_comb begin
      hex_ok = 1'b1;
      hex_val = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         hex_val = c[3:0];
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         hex_val = c[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (is_start) begin
            phase_in = nsd_pkg::PH_TALKER;
         end else begin
            case (phase_ff)
               nsd_pkg::PH_TALKER: begin
                  if (seen_ff == nsd_pkg::SEEN_W'(nsd_pkg::TALKER_CHARS - 1))
                     phase_in = nsd_pkg::PH_SEP;
               end
               nsd_pkg::PH_SEP: phase_in = nsd_pkg::PH_PAYLOAD;
               nsd_pkg::PH_PAYLOAD: begin
                  if (c == nsd_pkg::CHAR_STAR) phase_in = nsd_pkg::PH_CKHI;
                  else if (overlong) phase_in = nsd_pkg::PH_HUNT;
               end
               nsd_pkg::PH_CKHI: phase_in = hex_ok ? nsd_pkg::PH_CKLO : nsd_pkg::PH_HUNT;
               nsd_pkg::PH_CKLO: phase_in = hex_ok ? nsd_pkg::PH_CR : nsd_pkg::PH_HUNT;
               nsd_pkg::PH_CR: begin
                  phase_in = (c == nsd_pkg::CHAR_CR) ? nsd_pkg::PH_LF : nsd_pkg::PH_HUNT;
               end
               nsd_pkg::PH_LF: phase_in = nsd_pkg::PH_HUNT;
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   always_comb begin
      talker_in = talker_ff;
      seen_in = seen_ff;
      xor_in = xor_ff;
      sum_in = sum_ff;
      count_in = count_ff;
      res_valid = 1'b0;
      kind_in = nsd_pkg::KIND_REPORT;
      char_in = 8'd0;
      ok_in = 1'b0;
      status_in = nsd_pkg::ST_OK;
      count_out_in = count_ff;
      if (accept) begin
         if (is_start) begin
            talker_in = '0;
            seen_in = '0;
            xor_in = '0;
            sum_in = '0;
            count_in = '0;
         end else begin
            case (phase_ff)
               nsd_pkg::PH_TALKER: begin
                  xor_in = xor_ff ^ c;
                  talker_in = {talker_ff[nsd_pkg::TALKER_W-9:0], c};
                  seen_in = seen_ff + 1'b1;
               end
               nsd_pkg::PH_SEP: xor_in = xor_ff ^ c;
               nsd_pkg::PH_PAYLOAD: begin
                  if (c != nsd_pkg::CHAR_STAR) begin
                     res_valid = 1'b1;
                     if (overlong) begin
                        status_in = nsd_pkg::ST_OVERLONG;
                     end else begin
                        xor_in = xor_ff ^ c;
                        count_in = count_ff + 8'd1;
                        count_out_in = count_ff + 8'd1;
                        kind_in = nsd_pkg::KIND_PAYLOAD;
                        char_in = c;
                     end
                  end
               end
               nsd_pkg::PH_CKHI: begin
                  if (hex_ok) sum_in = {hex_val, 4'd0};
                  else begin
                     res_valid = 1'b1;
                     status_in = nsd_pkg::ST_BADHEX;
                  end
               end
               nsd_pkg::PH_CKLO: begin
                  if (hex_ok) sum_in = {sum_ff[7:4], hex_val};
                  else begin
                     res_valid = 1'b1;
                     status_in = nsd_pkg::ST_BADHEX;
                  end
               end
               nsd_pkg::PH_CR: begin
                  if (c != nsd_pkg::CHAR_CR) begin
                     res_valid = 1'b1;
                     ok_in = sum_match;
                     status_in = nsd_pkg::ST_NOCRLF;
                  end
               end
               nsd_pkg::PH_LF: begin
                  res_valid = 1'b1;
                  ok_in = sum_match;
                  status_in = (c == nsd_pkg::CHAR_LF) ? nsd_pkg::ST_OK : nsd_pkg::ST_NOCRLF;
               end
               default: res_valid = 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= nsd_pkg::PH_HUNT;
         talker_ff <= '0;
         seen_ff <= '0;
         xor_ff <= '0;
         sum_ff <= '0;
         count_ff <= '0;
         max_len_ff <= nsd_pkg::MAX_PAYLOAD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         talker_ff <= talker_in;
         seen_ff <= seen_in;
         xor_ff <= xor_in;
         sum_ff <= sum_in;
         count_ff <= count_in;
         if (csr_wr_en) max_len_ff <= csr_wr_data;
         if (accept) rsp_valid_ff <= res_valid;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         kind_ff <= kind_in;
         char_ff <= char_in;
         talker_out_ff <= talker_ff;
         ok_ff <= ok_in;
         status_ff <= status_in;
         count_out_ff <= count_out_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item_kind = kind_ff;
   assign rsp_payload_char = char_ff;
   assign rsp_talker_id = talker_out_ff;
   assign rsp_checksum_ok = ok_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_payload_count = count_out_ff;

endmodule

// File: src/nsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence deframer port checker
// Watches the top-level ports for result consistency and output flow rules.
// ----------------------------------------------------------------------------
module nsd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_item_kind,
   input logic [7:0]                  rsp_payload_char,
   input logic                        rsp_checksum_ok,
   input logic [1:0]                  rsp_frame_status,
   input logic [7:0]                  rsp_payload_count
);

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result beat dropped before it was taken.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Input stalled while the output register is empty.");

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == nsd_pkg::KIND_PAYLOAD |->
         rsp_frame_status == nsd_pkg::ST_OK && !rsp_checksum_ok
         && rsp_payload_count != 8'd0)
      else $error("Payload beat carries report fields.");

   a_report_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == nsd_pkg::KIND_REPORT |->
         rsp_payload_char == 8'd0
         && !(rsp_checksum_ok && (rsp_frame_status == nsd_pkg::ST_BADHEX
              || rsp_frame_status == nsd_pkg::ST_OVERLONG)))
      else $error("End report fields are inconsistent.");

endmodule

bind nmea_sentence_deframer_unit nsd_checker u_nsd_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_item_kind(rsp_item_kind),
   .rsp_payload_char(rsp_payload_char),
   .rsp_checksum_ok(rsp_checksum_ok),
   .rsp_frame_status(rsp_frame_status),
   .rsp_payload_count(rsp_payload_count)
);

// File: test/nmea_deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA deframer result checker
// Watches the character and result channels of the deframer. It tracks the
// length limit register and the sentence state on its own, works out the
// result of every accepted character beat and compares each result beat with
// the oldest one still awaited.
// ----------------------------------------------------------------------------
module nmea_deframer_checker
   import nsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [7:0]          req_rx_byte,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic                rsp_item_kind,
   input  logic [7:0]          rsp_payload_char,
   input  logic [TALKER_W-1:0] rsp_talker_id,
   input  logic                rsp_checksum_ok,
   input  logic [1:0]          rsp_frame_status,
   input  logic [7:0]          rsp_payload_count,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   output int                  mismatch_count,
   output int                  outstanding
);

   typedef struct packed {
      logic                kind;
      logic [7:0]          pchar;
      logic [TALKER_W-1:0] talker;
      logic                sum_ok;
      logic [1:0]          status;
      logic [7:0]          count;
   } deframed_item_t;

   deframed_item_t      awaited[$];
   phase_type           phase;
   logic [TALKER_W-1:0] talker_acc;
   logic [SEEN_W-1:0]   talker_cnt;
   logic [7:0]          xor_acc;
   logic [7:0]          sum_rx;
   logic [7:0]          pay_cnt;
   logic [7:0]          pay_limit;

   function automatic logic [4:0] nibble_of(input logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return 5'(ch - "0");
      if (ch >= "A" && ch <= "F") return 5'(ch - "A" + 10);
      if (ch >= "a" && ch <= "f") return 5'(ch - "a" + 10);
      return 5'd16;
   endfunction

   task automatic await_item(input logic kind, input logic [7:0] pchar,
                             input logic sum_ok, input logic [1:0] status);
      deframed_item_t e;
      e.kind = kind;
      e.pchar = pchar;
      e.talker = talker_acc;
      e.sum_ok = sum_ok;
      e.status = status;
      e.count = pay_cnt;
      awaited.push_back(e);
   endtask

   task automatic close_sentence(input logic sum_ok, input logic [1:0] status);
      await_item(KIND_REPORT, 8'h00, sum_ok, status);
      phase = PH_HUNT;
   endtask

   task automatic take_char(input logic [7:0] ch);
      logic [4:0] nib;
      nib = nibble_of(ch);
      if (ch == CHAR_START) begin
         talker_acc = '0;
         talker_cnt = '0;
         xor_acc = '0;
         sum_rx = '0;
         pay_cnt = '0;
         phase = PH_TALKER;
         return;
      end
      case (phase)
         PH_TALKER: begin
            xor_acc ^= ch;
            talker_acc = {talker_acc[TALKER_W-9:0], ch};
            talker_cnt++;
            if (talker_cnt >= TALKER_CHARS) phase = PH_SEP;
         end
         PH_SEP: begin
            xor_acc ^= ch;
            phase = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if (ch == CHAR_STAR) begin
               phase = PH_CKHI;
            end else if (pay_cnt >= pay_limit) begin
               close_sentence(1'b0, ST_OVERLONG);
            end else begin
               xor_acc ^= ch;
               pay_cnt++;
               await_item(KIND_PAYLOAD, ch, 1'b0, ST_OK);
            end
         end
         PH_CKHI: begin
            if (nib[4]) begin
               close_sentence(1'b0, ST_BADHEX);
            end else begin
               sum_rx = {nib[3:0], 4'h0};
               phase = PH_CKLO;
            end
         end
         PH_CKLO: begin
            if (nib[4]) begin
               close_sentence(1'b0, ST_BADHEX);
            end else begin
               sum_rx[3:0] = nib[3:0];
               phase = PH_CR;
            end
         end
         PH_CR: begin
            if (ch != CHAR_CR) close_sentence(sum_rx == xor_acc, ST_NOCRLF);
            else phase = PH_LF;
         end
         PH_LF: begin
            close_sentence(sum_rx == xor_acc, (ch == CHAR_LF) ? ST_OK : ST_NOCRLF);
         end
         default: ;
      endcase
   endtask

   task automatic flag_result(input string why, input deframed_item_t want,
                              input deframed_item_t got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t deframer %s: expected kind=%0d char=%h talker=%h ok=%0d",
                  $time, why, want.kind, want.pchar, want.talker, want.sum_ok,
                  " status=%0d count=%0d, got kind=%0d char=%h talker=%h ok=%0d",
                  want.status, want.count, got.kind, got.pchar, got.talker,
                  got.sum_ok, " status=%0d count=%0d", got.status, got.count);
   endtask

   always @(posedge clock) begin
      deframed_item_t got;
      deframed_item_t want;
      if (reset) begin
         awaited.delete();
         phase = PH_HUNT;
         talker_acc = '0;
         talker_cnt = '0;
         xor_acc = '0;
         sum_rx = '0;
         pay_cnt = '0;
         pay_limit = MAX_PAYLOAD_RESET;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.kind = rsp_item_kind;
            got.pchar = rsp_payload_char;
            got.talker = rsp_talker_id;
            got.sum_ok = rsp_checksum_ok;
            got.status = rsp_frame_status;
            got.count = rsp_payload_count;
            if (awaited.size() == 0) begin
               flag_result("result beat with nothing awaited", '0, got);
            end else begin
               want = awaited.pop_front();
               if (got.kind !== want.kind || got.pchar !== want.pchar ||
                   got.talker !== want.talker || got.sum_ok !== want.sum_ok ||
                   got.status !== want.status || got.count !== want.count)
                  flag_result("result mismatch", want, got);
            end
         end
         if (csr_wr_en) pay_limit = csr_wr_data;
         if (req_valid && req_ready) take_char(req_rx_byte);
      end
      outstanding <= awaited.size();
   end

endmodule

// File: test/tb_nmea_sentence_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence deframer testbench
// Feeds the deframer character streams of well-formed sentences with random
// talkers and payloads, mixed with wrong checksums, bad hex digits, missing
// line ends, overlong payloads, cut sentences and line noise, over several
// length limit settings. Both channels idle in random bursts. A checker
// module beside the block compares every result beat.
// ----------------------------------------------------------------------------
module tb_nmea_sentence_deframer_unit;

   localparam int WATCHDOG_CYCLES = 2000;
   localparam int PHASE_BEATS = 170;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;

   typedef enum int {
      FORM_GOOD,
      FORM_BADSUM,
      FORM_BADHEX_HI,
      FORM_BADHEX_LO,
      FORM_NOCR,
      FORM_NOLF
   } sentence_form_type;

   typedef logic [7:0] char_q_type[$];

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [7:0]                   req_rx_byte = 8'h00;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_item_kind;
   logic [7:0]                   rsp_payload_char;
   logic [nsd_pkg::TALKER_W-1:0] rsp_talker_id;
   logic                         rsp_checksum_ok;
   logic [1:0]                   rsp_frame_status;
   logic [7:0]                   rsp_payload_count;
   logic                         csr_wr_en = 1'b0;
   logic [7:0]                   csr_wr_data = 8'h00;

   int mismatch_count;
   int outstanding;
   int gap_pct = 0;
   int stall_pct = 0;
   int phase_beats = 0;
   int stall_run = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   nmea_sentence_deframer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_payload_char (rsp_payload_char),
      .rsp_talker_id    (rsp_talker_id),
      .rsp_checksum_ok  (rsp_checksum_ok),
      .rsp_frame_status (rsp_frame_status),
      .rsp_payload_count(rsp_payload_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   nmea_deframer_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_payload_char (rsp_payload_char),
      .rsp_talker_id    (rsp_talker_id),
      .rsp_checksum_ok  (rsp_checksum_ok),
      .rsp_frame_status (rsp_frame_status),
      .rsp_payload_count(rsp_payload_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   always begin
      @(posedge clock);
      if ($urandom_range(0, 99) < stall_pct) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      rsp_ready <= 1'b1;
   end

   initial begin
      while (stall_run < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_run = 0;
         else
            stall_run++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_char(input logic [7:0] ch, input bit counted);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= ch;
      do @(posedge clock); while (!req_ready);
      if (counted) phase_beats++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
      if (nib < 10) return 8'(8'h30 + nib);
      return 8'((lower ? 8'h61 : 8'h41) + nib - 10);
   endfunction

   function automatic logic [7:0] pick_not(input logic [7:0] avoid);
      logic [7:0] ch;
      do ch = 8'($urandom); while (ch == avoid || ch == nsd_pkg::CHAR_START);
      return ch;
   endfunction

   function automatic logic [7:0] pick_bad_hex();
      logic [7:0] ch;
      do begin
         ch = $urandom_range(0, 1) ? 8'($urandom_range(8'h2F, 8'h67)) : 8'($urandom);
      end while (ch == nsd_pkg::CHAR_START || (ch >= 8'h30 && ch <= 8'h39) ||
                 (ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66));
      return ch;
   endfunction

   function automatic logic [nsd_pkg::TALKER_W-1:0] make_talker();
      logic [nsd_pkg::TALKER_W-1:0] t;
      logic [7:0]                   ch;
      t = '0;
      repeat (nsd_pkg::TALKER_CHARS) begin
         do begin
            ch = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(8'h41, 8'h5A))
                                             : 8'($urandom);
         end while (ch == nsd_pkg::CHAR_START);
         t = {t[nsd_pkg::TALKER_W-9:0], ch};
      end
      return t;
   endfunction

   task automatic make_payload(input int len, output char_q_type text);
      logic [7:0] ch;
      text = {};
      repeat (len) begin
         do begin
            ch = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                             : 8'($urandom_range(8'h20, 8'h7E));
         end while (ch == nsd_pkg::CHAR_START || ch == nsd_pkg::CHAR_STAR);
         text.push_back(ch);
      end
   endtask

   task automatic send_sentence(input logic [nsd_pkg::TALKER_W-1:0] talker,
                                input logic [7:0] sep,
                                input char_q_type payload, input sentence_form_type form,
                                input bit lower, input int keep);
      char_q_type frame_bytes;
      logic [7:0] sum;
      logic [7:0] ch;
      frame_bytes = {nsd_pkg::CHAR_START};
      sum = sep;
      for (int i = nsd_pkg::TALKER_CHARS - 1; i >= 0; i--) begin
         ch = talker[i*8 +: 8];
         sum ^= ch;
         frame_bytes.push_back(ch);
      end
      frame_bytes.push_back(sep);
      foreach (payload[i]) begin
         sum ^= payload[i];
         frame_bytes.push_back(payload[i]);
      end
      frame_bytes.push_back(nsd_pkg::CHAR_STAR);
      if (form == FORM_BADSUM) sum ^= 8'($urandom_range(1, 255));
      frame_bytes.push_back(form == FORM_BADHEX_HI ? pick_bad_hex() : hex_char(sum[7:4], lower));
      if (form != FORM_BADHEX_HI) begin
         frame_bytes.push_back(form == FORM_BADHEX_LO ? pick_bad_hex()
                                                      : hex_char(sum[3:0], lower));
         if (form != FORM_BADHEX_LO) begin
            frame_bytes.push_back(form == FORM_NOCR ? pick_not(nsd_pkg::CHAR_CR)
                                                    : nsd_pkg::CHAR_CR);
            if (form != FORM_NOCR)
               frame_bytes.push_back(form == FORM_NOLF ? pick_not(nsd_pkg::CHAR_LF)
                                                       : nsd_pkg::CHAR_LF);
         end
      end
      foreach (frame_bytes[i])
         if (i < keep) send_char(frame_bytes[i], 1'b1);
   endtask

   task automatic send_random_sentence(input int limit);
      int                r;
      int                r2;
      int                plen;
      int                keep;
      char_q_type        text;
      sentence_form_type form;
      logic [7:0]        sep;
      r = $urandom_range(0, 99);
      if (r >= 95) begin
         repeat ($urandom_range(1, 4)) send_char(pick_not(nsd_pkg::CHAR_START), 1'b0);
         return;
      end
      if (r < 55) form = FORM_GOOD;
      else if (r < 65) form = FORM_BADSUM;
      else if (r < 72) form = FORM_BADHEX_HI;
      else if (r < 79) form = FORM_BADHEX_LO;
      else if (r < 85) form = FORM_NOCR;
      else if (r < 90) form = FORM_NOLF;
      else form = FORM_GOOD;
      r2 = $urandom_range(0, 9);
      if (r2 == 0 && limit <= 30) plen = limit + 1;
      else if (r2 == 1 && limit <= 30) plen = limit;
      else plen = $urandom_range(0, (limit < 13) ? limit + 1 : 14);
      keep = (r >= 90) ? $urandom_range(1, plen + 11) : plen + 12;
      sep = ($urandom_range(0, 4) != 0) ? CHAR_COMMA : pick_not(nsd_pkg::CHAR_START);
      make_payload(plen, text);
      send_sentence(make_talker(), sep, text, form, 1'($urandom_range(0, 1)), keep);
   endtask

   initial begin
      logic [7:0] limits [6];
      char_q_type text;
      limits = '{8'd1, 8'd7, 8'd255, 8'($urandom_range(1, 255)), 8'd80,
                 8'($urandom_range(2, 20))};
      gap_pct = 20;
      stall_pct = 20;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      text = '{8'hFF, 8'h00};
      send_sentence("GP*GA", CHAR_COMMA, text, FORM_GOOD, 1'b1, 64);
      send_char(nsd_pkg::CHAR_START, 1'b1);
      send_char("A", 1'b1);
      send_char("B", 1'b1);
      text = {};
      send_sentence("GPRMC", CHAR_COMMA, text, FORM_BADHEX_HI, 1'b0, 64);

      for (int p = 0; p < 6; p++) begin
         settle();
         csr_wr_en <= 1'b1;
         csr_wr_data <= limits[p];
         @(posedge clock);
         csr_wr_en <= 1'b0;
         gap_pct = (p == 5) ? 0 : 10 * $urandom_range(0, 3);
         stall_pct = (p == 5) ? 0 : 10 * $urandom_range(0, 3);
         phase_beats = 0;
         if (limits[p] == 8'd255) begin
            make_payload(255, text);
            send_sentence(make_talker(), CHAR_COMMA, text, FORM_GOOD, 1'b0, 300);
            make_payload(256, text);
            send_sentence(make_talker(), CHAR_COMMA, text, FORM_GOOD, 1'b1, 300);
         end
         while (phase_beats < PHASE_BEATS) send_random_sentence(int'(limits[p]));
      end
      settle();

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: files.f
src/nsd_pkg.sv
src/nmea_sentence_deframer_unit.sv
src/nsd_checker.sv
test/nmea_deframer_checker.sv
test/tb_nmea_sentence_deframer_unit.sv
